/* rtl/sts_pkg.sv */
`default_nettype none

package sts_pkg;

    // Width of the position and length counters; they saturate at all ones.
    localparam int POS_BITS = 16;
    localparam int OUT_BITS = 16;

    localparam int PREFIX_DEPTH = 6;
    localparam int PREFIX_IDX_BITS = $clog2(PREFIX_DEPTH);
    localparam int KW_COUNT = 9;

    // Result queue between the scanner and the result port.
    localparam int QDEPTH = 4;
    localparam int QPTR_BITS = $clog2(QDEPTH);
    localparam int QCNT_BITS = $clog2(QDEPTH + 1);

    typedef logic [POS_BITS-1:0] pos_t;

    typedef enum logic [4:0] {
        KIND_EQEQ   = 5'd0,
        KIND_EQLT   = 5'd1,
        KIND_EQGT   = 5'd2,
        KIND_EQNOT  = 5'd3,
        KIND_ASSIGN = 5'd4,
        KIND_NOT    = 5'd5,
        KIND_LT     = 5'd6,
        KIND_GT     = 5'd7,
        KIND_PLUS   = 5'd8,
        KIND_MINUS  = 5'd9,
        KIND_STAR   = 5'd10,
        KIND_SLASH  = 5'd11,
        KIND_LPAREN = 5'd12,
        KIND_RPAREN = 5'd13,
        KIND_LBRACE = 5'd14,
        KIND_RBRACE = 5'd15,
        KIND_SEMI   = 5'd16,
        KIND_COMMA  = 5'd17,
        KIND_DEN    = 5'd18,
        KIND_LET    = 5'd19,
        KIND_BE     = 5'd20,
        KIND_MUT    = 5'd21,
        KIND_TRUE   = 5'd22,
        KIND_FALSE  = 5'd23,
        KIND_RETURN = 5'd24,
        KIND_AND    = 5'd25,
        KIND_OR     = 5'd26,
        KIND_IDENT  = 5'd27,
        KIND_NUMBER = 5'd28,
        KIND_END    = 5'd29
    } kind_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_marker;
    } in_item_t;

    typedef struct packed {
        kind_t               token_kind;
        logic [OUT_BITS-1:0] start_offset;
        logic [OUT_BITS-1:0] token_length;
        logic                last_of_run;
    } out_item_t;

    localparam logic [7:0] CH_EQ     = "=";
    localparam logic [7:0] CH_LT     = "<";
    localparam logic [7:0] CH_GT     = ">";
    localparam logic [7:0] CH_BANG   = "!";
    localparam logic [7:0] CH_PLUS   = "+";
    localparam logic [7:0] CH_MINUS  = "-";
    localparam logic [7:0] CH_STAR   = "*";
    localparam logic [7:0] CH_SLASH  = "/";
    localparam logic [7:0] CH_LPAREN = "(";
    localparam logic [7:0] CH_RPAREN = ")";
    localparam logic [7:0] CH_LBRACE = "{";
    localparam logic [7:0] CH_RBRACE = "}";
    localparam logic [7:0] CH_SEMI   = ";";
    localparam logic [7:0] CH_COMMA  = ",";
    localparam logic [7:0] CH_SPACE  = " ";
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_NUL    = 8'd0;

    typedef logic [PREFIX_DEPTH-1:0][7:0] prefix_t;

    // Keyword text, first character in byte 0.
    localparam prefix_t KW_TEXT [KW_COUNT] = '{
        {CH_NUL, CH_NUL, CH_NUL, 8'("n"), 8'("e"), 8'("d")},
        {CH_NUL, CH_NUL, CH_NUL, 8'("t"), 8'("e"), 8'("l")},
        {CH_NUL, CH_NUL, CH_NUL, CH_NUL, 8'("e"), 8'("b")},
        {CH_NUL, CH_NUL, CH_NUL, 8'("t"), 8'("u"), 8'("m")},
        {CH_NUL, CH_NUL, 8'("e"), 8'("u"), 8'("r"), 8'("t")},
        {CH_NUL, 8'("e"), 8'("s"), 8'("l"), 8'("a"), 8'("f")},
        {8'("n"), 8'("r"), 8'("u"), 8'("t"), 8'("e"), 8'("r")},
        {CH_NUL, CH_NUL, CH_NUL, 8'("d"), 8'("n"), 8'("a")},
        {CH_NUL, CH_NUL, CH_NUL, CH_NUL, 8'("r"), 8'("o")}
    };

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd3, 3'd3, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd3, 3'd2
    };

    localparam kind_t KW_KIND [KW_COUNT] = '{
        KIND_DEN, KIND_LET, KIND_BE, KIND_MUT, KIND_TRUE, KIND_FALSE,
        KIND_RETURN, KIND_AND, KIND_OR
    };

endpackage

`default_nettype wire

/* rtl/source_token_scanner.sv */
// Source token scanner.
// The input channel (s_valid, s_ready, s_data) takes one source byte per item,
// or an end-of-source item with end_marker set. The result channel (m_valid,
// m_ready, m_data) gives tokens as kind, start offset and length; last_of_run
// marks the last token that one input item caused, and an item gives zero,
// one or two tokens.
// An accepted item is scanned in the same cycle and its tokens are written
// into a four-entry result queue, which is registered, before they reach
// m_data. One item is accepted per cycle as long as the queue has two free
// entries; the result port drains one token per cycle while m_ready is high,
// so a stream that mostly gives one token or none per byte runs at one byte
// per cycle, and each two-token item leaves an extra token for the port.
// When the receiver stalls, the queue fills and s_ready drops until two
// entries are free again; no token is lost or repeated.
// The end item emits any pending token, then an end token at the source
// length, and returns the scanner to its start state for the next source.
// Reset (aresetn low at a clock edge) empties the queue and clears the
// scanner state; the block is ready as soon as reset is released.
`default_nettype none

module source_token_scanner (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire sts_pkg::in_item_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output sts_pkg::out_item_t     m_data
);
    import sts_pkg::*;

    typedef enum logic [1:0] {
        MODE_IDLE,
        MODE_EQ,
        MODE_WORD,
        MODE_NUM
    } mode_t;

    localparam pos_t POS_MAX = '1;

    mode_t   mode_reg, mode_next;
    pos_t    byte_pos_reg, byte_pos_next;
    pos_t    tok_start_reg, tok_start_next;
    pos_t    tok_len_reg, tok_len_next;
    prefix_t prefix_reg, prefix_next;

    out_item_t               queue_reg [QDEPTH];
    logic [QPTR_BITS-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_BITS-1:0]    count_reg;

    logic        accept, pop;
    logic        do_flush, sec_valid, run_idle;
    out_item_t   flush_res, sec_res, entry0, entry1;
    logic [1:0]  push_n;
    logic [7:0]  c;
    kind_t       single_kind;
    logic        single_valid;

    function automatic logic is_letter(input logic [7:0] ch);
        return (ch >= 8'("a") && ch <= 8'("z")) || (ch >= 8'("A") && ch <= 8'("Z"));
    endfunction

    function automatic logic is_digit(input logic [7:0] ch);
        return ch >= 8'("0") && ch <= 8'("9");
    endfunction

    function automatic logic is_space(input logic [7:0] ch);
        return ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR);
    endfunction

    function automatic pos_t sat_inc(input pos_t v);
        return (v == POS_MAX) ? v : v + POS_BITS'(1);
    endfunction

    function automatic logic [OUT_BITS-1:0] clamp_out(input pos_t v);
        logic [31:0] ext;
        ext = 32'(v);
        return (ext > 32'hFFFF) ? 16'hFFFF : ext[OUT_BITS-1:0];
    endfunction

    // All nine keywords are compared in parallel; only bytes inside the
    // keyword's length are checked, so unwritten prefix bytes never matter.
    function automatic kind_t word_kind(input pos_t len, input prefix_t pre);
        kind_t kind;
        logic  match;
        kind = KIND_IDENT;
        if (len <= POS_BITS'(PREFIX_DEPTH)) begin
            for (int k = 0; k < KW_COUNT; k++) begin
                match = (len == POS_BITS'(KW_LEN[k]));
                for (int i = 0; i < PREFIX_DEPTH; i++) begin
                    if (3'(i) < KW_LEN[k] && pre[i] != KW_TEXT[k][i]) begin
                        match = 1'b0;
                    end
                end
                if (match) begin
                    kind = KW_KIND[k];
                end
            end
        end
        return kind;
    endfunction

    assign c       = s_data.char_code;
    assign s_ready = (count_reg <= QCNT_BITS'(QDEPTH - 2));
    assign accept  = s_valid && s_ready;
    assign m_valid = (count_reg != '0);
    assign pop     = m_valid && m_ready;
    assign m_data  = queue_reg[rd_ptr_reg];

    always_comb begin
        single_valid = 1'b1;
        single_kind  = KIND_NOT;
        case (c)
            CH_BANG:   single_kind = KIND_NOT;
            CH_LT:     single_kind = KIND_LT;
            CH_GT:     single_kind = KIND_GT;
            CH_PLUS:   single_kind = KIND_PLUS;
            CH_MINUS:  single_kind = KIND_MINUS;
            CH_STAR:   single_kind = KIND_STAR;
            CH_SLASH:  single_kind = KIND_SLASH;
            CH_LPAREN: single_kind = KIND_LPAREN;
            CH_RPAREN: single_kind = KIND_RPAREN;
            CH_LBRACE: single_kind = KIND_LBRACE;
            CH_RBRACE: single_kind = KIND_RBRACE;
            CH_SEMI:   single_kind = KIND_SEMI;
            CH_COMMA:  single_kind = KIND_COMMA;
            default:   single_valid = 1'b0;
        endcase
    end

    always_comb begin
        mode_next      = mode_reg;
        byte_pos_next  = byte_pos_reg;
        tok_start_next = tok_start_reg;
        tok_len_next   = tok_len_reg;
        prefix_next    = prefix_reg;
        do_flush       = 1'b0;
        sec_valid      = 1'b0;
        run_idle       = 1'b0;

        // The pending token, as it would be emitted if the current byte ends it.
        flush_res.start_offset = clamp_out(tok_start_reg);
        flush_res.last_of_run  = 1'b0;
        case (mode_reg)
            MODE_EQ: begin
                flush_res.token_kind   = KIND_ASSIGN;
                flush_res.token_length = OUT_BITS'(1);
            end
            MODE_WORD: begin
                flush_res.token_kind   = word_kind(tok_len_reg, prefix_reg);
                flush_res.token_length = clamp_out(tok_len_reg);
            end
            default: begin
                flush_res.token_kind   = KIND_NUMBER;
                flush_res.token_length = clamp_out(tok_len_reg);
            end
        endcase

        sec_res.token_kind   = single_kind;
        sec_res.start_offset = clamp_out(byte_pos_reg);
        sec_res.token_length = OUT_BITS'(1);
        sec_res.last_of_run  = 1'b1;

        if (s_data.end_marker) begin
            do_flush             = (mode_reg != MODE_IDLE);
            sec_valid            = 1'b1;
            sec_res.token_kind   = KIND_END;
            sec_res.token_length = '0;
            mode_next            = MODE_IDLE;
            byte_pos_next        = '0;
            tok_start_next       = '0;
            tok_len_next         = '0;
        end else begin
            byte_pos_next = sat_inc(byte_pos_reg);
            case (mode_reg)
                MODE_EQ: begin
                    if (c == CH_EQ || c == CH_LT || c == CH_GT || c == CH_BANG) begin
                        sec_valid            = 1'b1;
                        sec_res.start_offset = clamp_out(tok_start_reg);
                        sec_res.token_length = OUT_BITS'(2);
                        mode_next            = MODE_IDLE;
                        case (c)
                            CH_EQ:   sec_res.token_kind = KIND_EQEQ;
                            CH_LT:   sec_res.token_kind = KIND_EQLT;
                            CH_GT:   sec_res.token_kind = KIND_EQGT;
                            default: sec_res.token_kind = KIND_EQNOT;
                        endcase
                    end else begin
                        do_flush = 1'b1;
                        run_idle = 1'b1;
                    end
                end
                MODE_WORD: begin
                    if (is_letter(c) || is_digit(c)) begin
                        if (tok_len_reg < POS_BITS'(PREFIX_DEPTH)) begin
                            prefix_next[tok_len_reg[PREFIX_IDX_BITS-1:0]] = c;
                        end
                        tok_len_next = sat_inc(tok_len_reg);
                    end else begin
                        do_flush = 1'b1;
                        run_idle = 1'b1;
                    end
                end
                MODE_NUM: begin
                    if (is_digit(c)) begin
                        tok_len_next = sat_inc(tok_len_reg);
                    end else begin
                        do_flush = 1'b1;
                        run_idle = 1'b1;
                    end
                end
                default: begin
                    run_idle = 1'b1;
                end
            endcase

            // The byte starts fresh: it may open a new token or give one at once.
            if (run_idle) begin
                mode_next = MODE_IDLE;
                if (is_space(c)) begin
                    mode_next = MODE_IDLE;
                end else if (c == CH_EQ) begin
                    mode_next      = MODE_EQ;
                    tok_start_next = byte_pos_reg;
                end else if (single_valid) begin
                    sec_valid = 1'b1;
                end else if (is_letter(c)) begin
                    mode_next      = MODE_WORD;
                    tok_start_next = byte_pos_reg;
                    prefix_next[0] = c;
                    tok_len_next   = POS_BITS'(1);
                end else if (is_digit(c)) begin
                    mode_next      = MODE_NUM;
                    tok_start_next = byte_pos_reg;
                    tok_len_next   = POS_BITS'(1);
                end
            end
        end

        push_n = 2'(do_flush) + 2'(sec_valid);
        entry1 = sec_res;
        if (do_flush) begin
            entry0             = flush_res;
            entry0.last_of_run = !sec_valid;
        end else begin
            entry0 = sec_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_IDLE;
            byte_pos_reg  <= '0;
            tok_start_reg <= '0;
            tok_len_reg   <= '0;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            count_reg     <= '0;
        end else begin
            if (accept) begin
                mode_reg      <= mode_next;
                byte_pos_reg  <= byte_pos_next;
                tok_start_reg <= tok_start_next;
                tok_len_reg   <= tok_len_next;
                wr_ptr_reg    <= wr_ptr_reg + QPTR_BITS'(push_n);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_BITS'(1);
            end
            count_reg <= count_reg + QCNT_BITS'(accept ? push_n : 2'd0) - QCNT_BITS'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            prefix_reg <= prefix_next;
            if (push_n != 2'd0) begin
                queue_reg[wr_ptr_reg] <= entry0;
            end
            if (push_n == 2'd2) begin
                queue_reg[wr_ptr_reg + QPTR_BITS'(1)] <= entry1;
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= QCNT_BITS'(QDEPTH))
        else $error("result queue count exceeds its depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_data.end_marker) |=>
            (mode_reg == MODE_IDLE && byte_pos_reg == '0 && count_reg != '0))
        else $error("end item did not restart the scanner or queue its end token");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.token_kind == KIND_END) |->
            (m_data.token_length == '0 && m_data.last_of_run))
        else $error("end token with nonzero length or not last of its item");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !s_data.end_marker && mode_reg != MODE_IDLE) |=>
            (byte_pos_reg != '0))
        else $error("byte position failed to advance inside a token");

endmodule

`default_nettype wire

/* sim/token_checker.sv */
`default_nettype none

module token_checker (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic               s_ready,
    input  wire sts_pkg::in_item_t  s_data,
    input  wire logic               m_valid,
    input  wire logic               m_ready,
    input  wire sts_pkg::out_item_t m_data,
    output int                      mismatches,
    output int                      tokens_owed
);
    timeunit 1ns;
    timeprecision 1ps;

    import sts_pkg::*;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_EQ,
        SCAN_WORD,
        SCAN_NUM
    } scan_t;

    scan_t      scan = SCAN_IDLE;
    pos_t       src_pos = '0;
    pos_t       tok_start = '0;
    pos_t       tok_len = '0;
    logic [7:0] word_head [PREFIX_DEPTH];

    out_item_t  pending_tokens [$];
    int         tokens_this_item;
    int         failures = 0;

    function automatic pos_t bump(pos_t v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic bit is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_num(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    // The word is packed with its last byte lowest, so a short word compares
    // equal to a plain string literal of the same text.
    function automatic kind_t word_kind();
        logic [8*PREFIX_DEPTH-1:0] text;
        text = '0;
        if (tok_len > PREFIX_DEPTH) return KIND_IDENT;
        for (int i = 0; i < tok_len; i++)
            text = {text[8*PREFIX_DEPTH-9:0], word_head[i]};
        case (text)
            "den":    return KIND_DEN;
            "let":    return KIND_LET;
            "be":     return KIND_BE;
            "mut":    return KIND_MUT;
            "true":   return KIND_TRUE;
            "false":  return KIND_FALSE;
            "return": return KIND_RETURN;
            "and":    return KIND_AND;
            "or":     return KIND_OR;
            default:  return KIND_IDENT;
        endcase
    endfunction

    task automatic queue_token(kind_t kind, pos_t start, pos_t len);
        out_item_t t;
        t.token_kind   = kind;
        t.start_offset = start;
        t.token_length = len;
        t.last_of_run  = 1'b0;
        pending_tokens = {pending_tokens, t};
        tokens_this_item++;
    endtask

    task automatic restart_scan();
        scan      = SCAN_IDLE;
        src_pos   = '0;
        tok_start = '0;
        tok_len   = '0;
    endtask

    task automatic close_token();
        case (scan)
            SCAN_EQ:   queue_token(KIND_ASSIGN, tok_start, 1);
            SCAN_WORD: queue_token(word_kind(), tok_start, tok_len);
            SCAN_NUM:  queue_token(KIND_NUMBER, tok_start, tok_len);
            default: ;
        endcase
        scan = SCAN_IDLE;
    endtask

    task automatic from_idle(logic [7:0] c, pos_t at);
        kind_t kind;
        bit    single;
        kind   = KIND_IDENT;
        single = 1'b1;
        case (c)
            CH_BANG:   kind = KIND_NOT;
            CH_LT:     kind = KIND_LT;
            CH_GT:     kind = KIND_GT;
            CH_PLUS:   kind = KIND_PLUS;
            CH_MINUS:  kind = KIND_MINUS;
            CH_STAR:   kind = KIND_STAR;
            CH_SLASH:  kind = KIND_SLASH;
            CH_LPAREN: kind = KIND_LPAREN;
            CH_RPAREN: kind = KIND_RPAREN;
            CH_LBRACE: kind = KIND_LBRACE;
            CH_RBRACE: kind = KIND_RBRACE;
            CH_SEMI:   kind = KIND_SEMI;
            CH_COMMA:  kind = KIND_COMMA;
            default:   single = 1'b0;
        endcase
        if (is_blank(c)) begin
            return;
        end else if (c == CH_EQ) begin
            scan      = SCAN_EQ;
            tok_start = at;
        end else if (single) begin
            queue_token(kind, at, 1);
        end else if (is_alpha(c)) begin
            scan         = SCAN_WORD;
            tok_start    = at;
            word_head[0] = c;
            tok_len      = 1;
        end else if (is_num(c)) begin
            scan      = SCAN_NUM;
            tok_start = at;
            tok_len   = 1;
        end
    endtask

    task automatic scan_item(in_item_t it);
        logic [7:0] c;
        pos_t       here;
        out_item_t  t;
        c    = it.char_code;
        here = src_pos;
        tokens_this_item = 0;
        if (it.end_marker) begin
            close_token();
            queue_token(KIND_END, src_pos, 0);
            restart_scan();
        end else begin
            src_pos = bump(src_pos);
            case (scan)
                SCAN_EQ: begin
                    if (c == CH_EQ) begin
                        queue_token(KIND_EQEQ, tok_start, 2);
                        scan = SCAN_IDLE;
                    end else if (c == CH_LT) begin
                        queue_token(KIND_EQLT, tok_start, 2);
                        scan = SCAN_IDLE;
                    end else if (c == CH_GT) begin
                        queue_token(KIND_EQGT, tok_start, 2);
                        scan = SCAN_IDLE;
                    end else if (c == CH_BANG) begin
                        queue_token(KIND_EQNOT, tok_start, 2);
                        scan = SCAN_IDLE;
                    end else begin
                        close_token();
                        from_idle(c, here);
                    end
                end
                SCAN_WORD: begin
                    if (is_alpha(c) || is_num(c)) begin
                        if (tok_len < PREFIX_DEPTH) word_head[tok_len] = c;
                        tok_len = bump(tok_len);
                    end else begin
                        close_token();
                        from_idle(c, here);
                    end
                end
                SCAN_NUM: begin
                    if (is_num(c)) begin
                        tok_len = bump(tok_len);
                    end else begin
                        close_token();
                        from_idle(c, here);
                    end
                end
                default: from_idle(c, here);
            endcase
        end
        if (tokens_this_item > 0) begin
            t = pending_tokens.pop_back();
            t.last_of_run = 1'b1;
            pending_tokens = {pending_tokens, t};
        end
    endtask

    always @(posedge aclk) begin : monitor
        out_item_t want;
        if (!aresetn) begin
            restart_scan();
            pending_tokens.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (pending_tokens.size() == 0) begin
                    if (failures < 10)
                        $display("%0t: unexpected token kind %0d start %0d len %0d last %0d",
                                 $time, m_data.token_kind, m_data.start_offset,
                                 m_data.token_length, m_data.last_of_run);
                    failures++;
                end else begin
                    want = pending_tokens.pop_front();
                    if (m_data.token_kind !== want.token_kind ||
                        m_data.start_offset !== want.start_offset ||
                        m_data.token_length !== want.token_length ||
                        m_data.last_of_run !== want.last_of_run) begin
                        if (failures < 10)
                            $display("%0t: token mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                     $time, want.token_kind, want.start_offset,
                                     want.token_length, want.last_of_run,
                                     m_data.token_kind, m_data.start_offset,
                                     m_data.token_length, m_data.last_of_run);
                        failures++;
                    end
                end
            end
            if (s_valid && s_ready) scan_item(s_data);
        end
        mismatches  <= failures;
        tokens_owed <= pending_tokens.size();
    end

endmodule

`default_nettype wire

/* sim/testbench.sv */
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import sts_pkg::*;

    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 950;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    int mismatches;
    int tokens_owed;
    int sent = 0;
    int quiet = 0;
    bit tx_steady = 1'b0;

    string      keywords [9] = '{"den", "let", "be", "mut", "true", "false",
                                 "return", "and", "or"};
    logic [7:0] punct [13] = '{CH_BANG, CH_LT, CH_GT, CH_PLUS, CH_MINUS, CH_STAR,
                               CH_SLASH, CH_LPAREN, CH_RPAREN, CH_LBRACE,
                               CH_RBRACE, CH_SEMI, CH_COMMA};

    always #5 aclk = ~aclk;

    source_token_scanner dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    token_checker token_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .mismatches  (mismatches),
        .tokens_owed (tokens_owed)
    );

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet <= 0;
        end else if (quiet >= STALL_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (tx_steady || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [7:0] rand_alnum(bit letters_only);
        int r;
        r = letters_only ? $urandom_range(0, 51) : $urandom_range(0, 61);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        return 8'("0" + r - 52);
    endfunction

    task automatic send_item(logic [7:0] c, logic fin);
        in_item_t it;
        int       gap;
        it.char_code  = c;
        it.end_marker = fin;
        gap = idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    task automatic send_text(string txt);
        int i;
        for (i = 0; i < txt.len(); i++) send_item(txt[i], 1'b0);
    endtask

    // One well-formed token most of the time, with some noise and early ends.
    task automatic send_token();
        int         pick;
        int         variant;
        int         n;
        int         i;
        string      kw;
        logic [7:0] ch;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            kw      = keywords[$urandom_range(0, 8)];
            variant = $urandom_range(0, 9);
            for (i = 0; i < kw.len(); i++) begin
                ch = kw[i];
                if (variant == 0 && i == 0) ch = ch ^ 8'h20;
                if (!(variant == 1 && i == kw.len() - 1)) send_item(ch, 1'b0);
            end
            if (variant == 2) send_item(rand_alnum(1'b0), 1'b0);
        end else if (pick < 40) begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
            send_item(rand_alnum(1'b1), 1'b0);
            for (i = 1; i < n; i++) send_item(rand_alnum(1'b0), 1'b0);
        end else if (pick < 52) begin
            n = $urandom_range(1, 5);
            for (i = 0; i < n; i++) send_item(8'("0" + $urandom_range(0, 9)), 1'b0);
        end else if (pick < 62) begin
            send_item(CH_EQ, 1'b0);
            case ($urandom_range(0, 3))
                0:       send_item(CH_EQ, 1'b0);
                1:       send_item(CH_LT, 1'b0);
                2:       send_item(CH_GT, 1'b0);
                default: send_item(CH_BANG, 1'b0);
            endcase
        end else if (pick < 68) begin
            send_item(CH_EQ, 1'b0);
        end else if (pick < 88) begin
            send_item(punct[$urandom_range(0, 12)], 1'b0);
        end else if (pick < 95) begin
            send_item(8'($urandom_range(0, 255)), 1'b0);
        end else begin
            send_item(8'($urandom_range(0, 255)), 1'b1);
        end
        if ($urandom_range(0, 99) < 65) begin
            if ($urandom_range(0, 5) == 5) send_item(CH_SPACE, 1'b0);
            else send_item(8'($urandom_range(9, 13)), 1'b0);
        end
    endtask

    // Result side: ready stretches and stalls of random length, with a long
    // periodic hold-off so the result queue fills up.
    initial begin : result_sink
        int busy;
        int low;
        int r;
        int elapsed;
        int hold_at;
        elapsed = 0;
        hold_at = 300;
        while (!aresetn) @(posedge aclk);
        forever begin
            busy = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200)
                                                : $urandom_range(1, 12);
            m_ready <= 1'b1;
            repeat (busy) @(posedge aclk);
            elapsed += busy;
            r = $urandom_range(0, 99);
            if (elapsed >= hold_at) begin
                low     = 150;
                hold_at = elapsed + 2000;
            end else if (r < 45) begin
                low = 0;
            end else if (r < 90) begin
                low = $urandom_range(1, 3);
            end else begin
                low = $urandom_range(8, 25);
            end
            if (low > 0) begin
                m_ready <= 1'b0;
                repeat (low) @(posedge aclk);
                elapsed += low;
            end
        end
    end

    initial begin : source_feed
        int tokens;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Every two-character compare, then a pending '=' broken by another
        // operator, a word too long to be a keyword ended by a non-ASCII byte,
        // a number ended by 0xFF, whitespace, a NUL byte, and a pending '='
        // flushed by an end item whose byte must be ignored.
        send_text("===<=>=!=(returns");
        send_item(8'h80, 1'b0);
        send_text("42");
        send_item(8'hFF, 1'b0);
        send_item(CH_TAB, 1'b0);
        send_item(CH_NUL, 1'b0);
        send_item(CH_EQ, 1'b0);
        send_item(8'hFF, 1'b1);

        tokens = 0;
        while (sent < 25 + RANDOM_ITEMS) begin
            if (tokens % 30 == 0) tx_steady = ($urandom_range(0, 3) == 0);
            send_token();
            tokens++;
        end
        send_item(8'($urandom_range(0, 255)), 1'b1);

        s_valid <= 1'b0;
        @(posedge aclk);
        while (tokens_owed != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
